[rtl/core/temporal_frame_selector_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame selector
// Clocked, reset-qualified wrappers used by the RTL that carries checks.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_FRAME_SELECTOR_ASSERT_SVH
`define TEMPORAL_FRAME_SELECTOR_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define TFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent
`define TFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/tfs_pkg.sv]
// ----------------------------------------------------------------------------
// tfs_pkg
// Widths, register codes, reset values and shared types of the frame selector.
// ----------------------------------------------------------------------------
package tfs_pkg;

  // Parameter defaults
  localparam int MAX_FRAMES_DEF = 8;
  localparam int SLOT_DEPTH_DEF = 16;

  // Field widths
  localparam int STAMP_W     = 63;
  localparam int INTERVAL_W  = 32;
  localparam int TOL_W       = 32;
  localparam int FRAME_CNT_W = 4;
  localparam int STEP_W      = 3;
  localparam int SLOT_W      = 4;
  localparam int KEPT_W      = 5;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_DUP  = 8'd3;

  // Register reset values
  localparam logic [FRAME_CNT_W-1:0] FRAME_COUNT_RST = 4'd2;
  localparam logic [INTERVAL_W-1:0]  INTERVAL_RST    = 32'd100000000;
  localparam logic [TOL_W-1:0]       TOLERANCE_RST   = 32'd50000000;

  // Insert status codes
  typedef enum logic [STATUS_W-1:0] {
    INS_FIRST  = 2'd0,
    INS_CONSEC = 2'd1,
    INS_GAP    = 2'd2
  } ins_status_t;

  // Per-cycle commands broadcast to every cell of the slot chain
  typedef struct packed {
    logic shift;     // push a new stamp in at the head
    logic age_load;  // latch age against the head stamp
  } cell_ctl_t;

endpackage

[rtl/core/tfs_if.sv]
// ----------------------------------------------------------------------------
// Frame selector channels
// Valid/ready interfaces for the stamp input, the result output and the
// register write port.
// ----------------------------------------------------------------------------
interface tfs_in_if;
  import tfs_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] stamp_ns;

  modport source (output valid, output stamp_ns, input ready);
  modport sink   (input valid, input stamp_ns, output ready);
endinterface

interface tfs_out_if;
  import tfs_pkg::*;

  logic                valid;
  logic                ready;
  logic [STEP_W-1:0]   step_index;
  logic [SLOT_W-1:0]   chosen_slot;
  logic                found;
  logic [STATUS_W-1:0] insert_status;
  logic                is_ready;
  logic [KEPT_W-1:0]   kept_count;
  logic                last;

  modport source (output valid, output step_index, output chosen_slot, output found,
                  output insert_status, output is_ready, output kept_count,
                  output last, input ready);
  modport sink   (input valid, input step_index, input chosen_slot, input found,
                  input insert_status, input is_ready, input kept_count,
                  input last, output ready);
endinterface

interface tfs_cfg_if;
  import tfs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[rtl/core/tfs_cell.sv]
// ----------------------------------------------------------------------------
// tfs_cell
// One slot of the newest-first stamp chain. Holds a stamp and its age, and
// refines a passing search token against its own age.
// ----------------------------------------------------------------------------
module tfs_cell #(
  parameter int CELL_IDX   = 0,
  parameter int MAX_FRAMES = tfs_pkg::MAX_FRAMES_DEF,
  parameter int SLOT_DEPTH = tfs_pkg::SLOT_DEPTH_DEF,
  localparam int STW = $clog2(MAX_FRAMES),
  localparam int SW  = $clog2(SLOT_DEPTH),
  localparam int FW  = $clog2(SLOT_DEPTH + 1),
  localparam int TW  = tfs_pkg::INTERVAL_W + STW
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tfs_pkg::cell_ctl_t           ctl,
  input  logic [tfs_pkg::STAMP_W-1:0]  stamp_in,
  input  logic [tfs_pkg::STAMP_W-1:0]  head_stamp,
  input  logic [FW-1:0]                fill,
  input  logic [tfs_pkg::TOL_W-1:0]    tolerance,
  input  logic                         tok_in_valid,
  input  logic [STW-1:0]               tok_in_step,
  input  logic [TW-1:0]                tok_in_target,
  input  logic                         tok_in_have,
  input  logic [tfs_pkg::TOL_W-1:0]    tok_in_best,
  input  logic [SW-1:0]                tok_in_idx,
  output logic [tfs_pkg::STAMP_W-1:0]  stamp_out,
  output logic [tfs_pkg::STAMP_W-1:0]  age_out,
  output logic                         tok_out_valid,
  output logic [STW-1:0]               tok_out_step,
  output logic [TW-1:0]                tok_out_target,
  output logic                         tok_out_have,
  output logic [tfs_pkg::TOL_W-1:0]    tok_out_best,
  output logic [SW-1:0]                tok_out_idx
);
  import tfs_pkg::*;

  logic [STAMP_W-1:0] stamp_r;
  logic [STAMP_W-1:0] age_r;
  logic               tok_valid_r;
  logic [STW-1:0]     tok_step_r;
  logic [TW-1:0]      tok_target_r;
  logic               tok_have_r;
  logic [TOL_W-1:0]   tok_best_r;
  logic [SW-1:0]      tok_idx_r;

  logic [STAMP_W-1:0] target_ext;
  logic [STAMP_W-1:0] err;
  logic               in_list;
  logic               take;

  // Shift the stamp along the chain, latch its age
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      stamp_r <= stamp_in;
    end
    if (ctl.age_load) begin
      age_r <= head_stamp - stamp_r;
    end
  end

  // Distance of this slot's age from the token's target
  always_comb begin
    target_ext = STAMP_W'(tok_in_target);
    err        = (age_r >= target_ext) ? (age_r - target_ext) : (target_ext - age_r);
    in_list    = FW'(CELL_IDX) < fill;
    take       = in_list && (err <= STAMP_W'(tolerance)) &&
                 (!tok_in_have || (err[TOL_W-1:0] < tok_in_best));
  end

  // Advance the search token, adopting this slot when strictly closer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_step_r   <= tok_in_step;
    tok_target_r <= tok_in_target;
    if (take) begin
      tok_have_r <= 1'b1;
      tok_best_r <= err[TOL_W-1:0];
      tok_idx_r  <= SW'(CELL_IDX);
    end else begin
      tok_have_r <= tok_in_have;
      tok_best_r <= tok_in_best;
      tok_idx_r  <= tok_in_idx;
    end
  end

  assign stamp_out      = stamp_r;
  assign age_out        = age_r;
  assign tok_out_valid  = tok_valid_r;
  assign tok_out_step   = tok_step_r;
  assign tok_out_target = tok_target_r;
  assign tok_out_have   = tok_have_r;
  assign tok_out_best   = tok_best_r;
  assign tok_out_idx    = tok_idx_r;

endmodule

[rtl/core/temporal_frame_selector.sv]
// ----------------------------------------------------------------------------
// temporal_frame_selector
// Keeps a newest-first chain of frame stamps and, per new frame, picks the
// stored frame nearest each history step within tolerance.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | stamp_ns
//  out_ch  | out | valid / ready | step_index chosen_slot found insert_status
//          |     |               | is_ready kept_count last
//  cfg_ch  | in  | valid / ready | reg_index wdata (always ready)
//
//  A stamp is pushed, its slot ages are latched and evicted slots drop out one
//  per cycle; one search token per effective frame then crosses the slot chain
//  one cell per cycle. Words then leave at one per cycle while out_ch is ready;
//  the next stamp is taken once the last word is registered. A stalled out_ch
//  holds its word and blocks later words and the next stamp. Reset (rst_n low,
//  synchronous) empties the list and restores the registers; no clearing pass.
// ----------------------------------------------------------------------------
module temporal_frame_selector #(
  parameter int MAX_FRAMES = tfs_pkg::MAX_FRAMES_DEF,
  parameter int SLOT_DEPTH = tfs_pkg::SLOT_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  tfs_in_if.sink      in_ch,
  tfs_out_if.source   out_ch,
  tfs_cfg_if.sink     cfg_ch
);
  import tfs_pkg::*;

  `include "temporal_frame_selector_assert.svh"

  localparam int STW = $clog2(MAX_FRAMES);
  localparam int SW  = $clog2(SLOT_DEPTH);
  localparam int FW  = $clog2(SLOT_DEPTH + 1);
  localparam int FRW = $clog2(MAX_FRAMES + 1);
  localparam int TW  = INTERVAL_W + STW;
  localparam int PW  = INTERVAL_W + FRW;
  localparam int WW  = PW + 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_AGE   = 5'b00010,
    ST_EVICT = 5'b00100,
    ST_SEL   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Registers
  logic [FRAME_CNT_W-1:0] frame_count_r;
  logic [INTERVAL_W-1:0]  interval_r;
  logic [TOL_W-1:0]       tolerance_r;
  logic                   warmup_dup_r;

  // Per-item control
  logic [FW-1:0]    fill_r;
  ins_status_t      status_r;
  logic [PW-1:0]    prod_r;
  logic [WW-1:0]    window_r;
  logic [FRW-1:0]   feed_r;
  logic [TW-1:0]    target_r;
  logic [STW-1:0]   emit_r;
  logic             all_found_r;

  // Result buffer, one entry per step
  logic [SW-1:0]    res_slot_r  [MAX_FRAMES];
  logic             res_found_r [MAX_FRAMES];

  // Output register
  logic                out_valid_r;
  logic [STEP_W-1:0]   out_step_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_found_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_ready_flag_r;
  logic [KEPT_W-1:0]   out_kept_r;
  logic                out_last_r;

  // Chain links
  logic [STAMP_W-1:0] stamp_q  [SLOT_DEPTH];
  logic [STAMP_W-1:0] age_q    [SLOT_DEPTH];
  logic [STAMP_W-1:0] stamp_ln [SLOT_DEPTH];
  logic               tok_v    [SLOT_DEPTH+1];
  logic [STW-1:0]     tok_s    [SLOT_DEPTH+1];
  logic [TW-1:0]      tok_t    [SLOT_DEPTH+1];
  logic               tok_h    [SLOT_DEPTH+1];
  logic [TOL_W-1:0]   tok_b    [SLOT_DEPTH+1];
  logic [SW-1:0]      tok_i    [SLOT_DEPTH+1];

  cell_ctl_t        cell_ctl;
  logic [FRW-1:0]   frames_eff;
  logic [FRW-1:0]   frames_m1;
  logic             in_fire;
  ins_status_t      status_nxt;
  logic [FW-1:0]    fill_base;
  logic [FW-1:0]    tail_pos;
  logic             evict_hit;
  logic             exit_fire;
  logic             exit_last;
  logic             emit_load;
  logic             emit_last;

  // Clamp the frame count into its working range
  always_comb begin
    if (frame_count_r < FRAME_CNT_W'(2)) begin
      frames_eff = FRW'(2);
    end else if (int'(frame_count_r) > MAX_FRAMES) begin
      frames_eff = FRW'(MAX_FRAMES);
    end else begin
      frames_eff = FRW'(frame_count_r);
    end
    frames_m1 = frames_eff - 1'b1;
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Classify the incoming stamp and size the list after the push
  always_comb begin
    if (fill_r == '0) begin
      status_nxt = INS_FIRST;
    end else if (in_ch.stamp_ns <= stamp_q[0]) begin
      status_nxt = INS_GAP;
    end else begin
      status_nxt = INS_CONSEC;
    end
    if (status_nxt != INS_CONSEC) begin
      fill_base = '0;
    end else if (fill_r >= FW'(SLOT_DEPTH)) begin
      fill_base = FW'(SLOT_DEPTH - 1);
    end else begin
      fill_base = fill_r;
    end
  end

  // Oldest kept slot against the age window
  assign tail_pos  = fill_r - 1'b1;
  assign evict_hit = (fill_r > FW'(1)) && (age_q[tail_pos[SW-1:0]] > STAMP_W'(window_r));

  assign exit_fire = tok_v[SLOT_DEPTH];
  assign exit_last = exit_fire && (FRW'(tok_s[SLOT_DEPTH]) == frames_m1);
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign emit_last = (FRW'(emit_r) == frames_m1);

  // Sequence: push, ages, evict, search, emit
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_AGE;
      end
      ST_AGE: begin
        state_nxt = ST_EVICT;
      end
      ST_EVICT: begin
        if (!evict_hit) state_nxt = ST_SEL;
      end
      ST_SEL: begin
        if (exit_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load && emit_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
      interval_r    <= INTERVAL_RST;
      tolerance_r   <= TOLERANCE_RST;
      warmup_dup_r  <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.reg_index)
        CFG_FRAME_COUNT: frame_count_r <= cfg_ch.wdata[FRAME_CNT_W-1:0];
        CFG_INTERVAL:    interval_r    <= cfg_ch.wdata[INTERVAL_W-1:0];
        CFG_TOLERANCE:   tolerance_r   <= cfg_ch.wdata[TOL_W-1:0];
        CFG_WARMUP_DUP:  warmup_dup_r  <= cfg_ch.wdata[0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      feed_r      <= '0;
      emit_r      <= '0;
      all_found_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        fill_r <= fill_base + 1'b1;
      end else if (state_r == ST_EVICT && evict_hit) begin
        fill_r <= fill_r - 1'b1;
      end
      if (state_r == ST_EVICT) begin
        feed_r      <= '0;
        all_found_r <= 1'b1;
      end else if (state_r == ST_SEL) begin
        if (feed_r < frames_eff) feed_r <= feed_r + 1'b1;
        if (exit_fire && !tok_h[SLOT_DEPTH]) all_found_r <= 1'b0;
      end
      if (state_r == ST_SEL) begin
        emit_r <= '0;
      end else if (emit_load) begin
        emit_r <= emit_r + 1'b1;
      end
    end
  end

  // Item data: status, window product and running target
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      prod_r   <= PW'(frames_m1) * PW'(interval_r);
    end
    if (state_r == ST_AGE) begin
      window_r <= WW'(prod_r) + WW'(tolerance_r);
    end
    if (state_r == ST_EVICT) begin
      target_r <= '0;
    end else if (state_r == ST_SEL) begin
      target_r <= target_r + TW'(interval_r);
    end
  end

  // Collect search results as tokens leave the chain
  always_ff @(posedge clk) begin
    if (exit_fire) begin
      res_slot_r[tok_s[SLOT_DEPTH]]  <= tok_i[SLOT_DEPTH];
      res_found_r[tok_s[SLOT_DEPTH]] <= tok_h[SLOT_DEPTH];
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_step_r       <= STEP_W'(emit_r);
      out_slot_r       <= SLOT_W'(res_slot_r[emit_r]);
      out_found_r      <= res_found_r[emit_r];
      out_status_r     <= status_r;
      out_ready_flag_r <= warmup_dup_r || all_found_r;
      out_kept_r       <= KEPT_W'(fill_r);
      out_last_r       <= emit_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.step_index    = out_step_r;
  assign out_ch.chosen_slot   = out_slot_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.insert_status = out_status_r;
  assign out_ch.is_ready      = out_ready_flag_r;
  assign out_ch.kept_count    = out_kept_r;
  assign out_ch.last          = out_last_r;

  // Chain commands and token injection
  assign cell_ctl.shift    = in_fire;
  assign cell_ctl.age_load = (state_r == ST_AGE);

  assign tok_v[0] = (state_r == ST_SEL) && (feed_r < frames_eff);
  assign tok_s[0] = feed_r[STW-1:0];
  assign tok_t[0] = target_r;
  assign tok_h[0] = 1'b0;
  assign tok_b[0] = '0;
  assign tok_i[0] = '0;

  // Slot chain, newest at cell zero
  for (genvar g = 0; g < SLOT_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign stamp_ln[g] = in_ch.stamp_ns;
    end else begin : g_body
      assign stamp_ln[g] = stamp_q[g-1];
    end

    tfs_cell #(
      .CELL_IDX   (g),
      .MAX_FRAMES (MAX_FRAMES),
      .SLOT_DEPTH (SLOT_DEPTH)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl            (cell_ctl),
      .stamp_in       (stamp_ln[g]),
      .head_stamp     (stamp_q[0]),
      .fill           (fill_r),
      .tolerance      (tolerance_r),
      .tok_in_valid   (tok_v[g]),
      .tok_in_step    (tok_s[g]),
      .tok_in_target  (tok_t[g]),
      .tok_in_have    (tok_h[g]),
      .tok_in_best    (tok_b[g]),
      .tok_in_idx     (tok_i[g]),
      .stamp_out      (stamp_q[g]),
      .age_out        (age_q[g]),
      .tok_out_valid  (tok_v[g+1]),
      .tok_out_step   (tok_s[g+1]),
      .tok_out_target (tok_t[g+1]),
      .tok_out_have   (tok_h[g+1]),
      .tok_out_best   (tok_b[g+1]),
      .tok_out_idx    (tok_i[g+1])
    );
  end

  // Checks
  `TFS_ASSERT(a_fill_range, (state_r == ST_IDLE) || ((fill_r != '0) && (fill_r <= FW'(SLOT_DEPTH))), "slot count out of range while busy")
  `TFS_ASSERT_NEXT(a_evict_step, (state_r == ST_EVICT) && (state_nxt == ST_EVICT), fill_r == $past(fill_r) - 1'b1, "eviction cycle without one slot dropped")
  `TFS_ASSERT_NEXT(a_accept_age, in_fire, state_r == ST_AGE, "accepted stamp not followed by age pass")

endmodule
